// File: rtl/drc_pkg.sv
// drc_pkg: shared types, constants and helper functions of the dirty rectangle coalescer
// no dependencies; imported by every module of the block
package drc_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int TABLE_DEPTH = 16;

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int EDGE_W = COORD_WIDTH + 2;
   localparam int LIM_W  = (CNT_W > 5) ? CNT_W : 5;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam logic [1:0] MODE_CLEAN = 2'd0;
   localparam logic [1:0] MODE_DIRTY = 2'd1;
   localparam logic [1:0] MODE_FULL  = 2'd2;

   typedef enum logic [2:0] {
      REG_VP_X,
      REG_VP_Y,
      REG_VP_W,
      REG_VP_H,
      REG_MARGIN,
      REG_RECT_LIMIT
   } reg_index_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [COORD_WIDTH-1:0]        size_type;
   typedef logic signed [EDGE_W-1:0]      edge_type;

   typedef struct packed {
      logic      opcode;
      coord_type rect_x;
      coord_type rect_y;
      size_type  rect_width;
      size_type  rect_height;
   } req_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       fallback;
      coord_type  out_x;
      coord_type  out_y;
      size_type   out_width;
      size_type   out_height;
      logic       last;
   } rsp_type;

   typedef struct packed {
      coord_type  viewport_x;
      coord_type  viewport_y;
      size_type   viewport_width;
      size_type   viewport_height;
      logic [7:0] margin;
      logic [4:0] rect_limit;
   } cfg_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      size_type  w;
      size_type  h;
   } rect_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_EMIT,
      ST_FIXED
   } state_type;

   typedef struct packed {
      logic edge_load;
      logic add_commit;
      logic emit_entry;
      logic emit_fixed;
      logic count_clear;
   } cmd_type;

   typedef struct packed {
      logic op_finish;
      logic vp_empty;
      logic tbl_empty;
      logic idx_last;
      logic out_free;
   } sts_type;

   // clamp a widened edge back into the signed coordinate range
   function automatic coord_type sat_edge(input edge_type v);
      logic [EDGE_W-COORD_WIDTH:0] top;
      coord_type                   res;
      top = v[EDGE_W-1:COORD_WIDTH-1];
      if ((&top) || !(|top)) begin
         res = v[COORD_WIDTH-1:0];
      end else if (v[EDGE_W-1]) begin
         res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
      return res;
   endfunction

   function automatic coord_type cmax(input coord_type a, input coord_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic coord_type cmin(input coord_type a, input coord_type b);
      return (a < b) ? a : b;
   endfunction

   // span between two in-range edges, right above left
   function automatic size_type span(input coord_type lo_e, input coord_type hi_e);
      logic signed [COORD_WIDTH:0] d;
      d = (COORD_WIDTH+1)'(hi_e) - (COORD_WIDTH+1)'(lo_e);
      return d[COORD_WIDTH-1:0];
   endfunction

endpackage

// File: rtl/dirty_rect_coalescer.sv
// dirty_rect_coalescer: top level, ties register file, controller and datapath together
// depends on drc_pkg, drc_regs, drc_ctrl and drc_dp
//
//   channel   direction   handshake              payload
//   req       in          req_valid/req_stall    drc_pkg::req_type
//   rsp       out         rsp_valid/rsp_stall    drc_pkg::rsp_type
//   csr       in/out      apb psel/penable       32-bit registers at 4*index
//
// an add item goes through edge growth and saturation, then clip and table write
// (or union into entry zero, read from the table ahead of time)
// a finish item streams the stored rectangles one per cycle unless the result stalls,
// set by the table's single registered read port; clean and full-frame results
// come as one last result; synchronous reset clears state, entry count, result valid
// and registers; no table clearing pass
// a stalled result holds the table walk; new items wait until the finish is done
module dirty_rect_coalescer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  drc_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output drc_pkg::rsp_type               rsp_payload,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [drc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [drc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [drc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import drc_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   drc_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   drc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   drc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cfg         (cfg),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: rtl/drc_regs.sv
// drc_regs: configuration register file behind the apb-style port
// depends on drc_pkg for the register index codes and the cfg_type struct
module drc_regs (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [drc_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [drc_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [drc_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready,
   output drc_pkg::cfg_type                      cfg
);
   import drc_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx        = reg_index_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_VP_X:       cfg_in.viewport_x      = csr_pwdata[COORD_WIDTH-1:0];
            REG_VP_Y:       cfg_in.viewport_y      = csr_pwdata[COORD_WIDTH-1:0];
            REG_VP_W:       cfg_in.viewport_width  = csr_pwdata[COORD_WIDTH-1:0];
            REG_VP_H:       cfg_in.viewport_height = csr_pwdata[COORD_WIDTH-1:0];
            REG_MARGIN:     cfg_in.margin          = csr_pwdata[7:0];
            REG_RECT_LIMIT: cfg_in.rect_limit      = csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{viewport_x: '0, viewport_y: '0, viewport_width: '0,
                     viewport_height: '0, margin: '0, rect_limit: 5'd16};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_VP_X:       csr_prdata = CSR_DATA_W'($unsigned(cfg_ff.viewport_x));
         REG_VP_Y:       csr_prdata = CSR_DATA_W'($unsigned(cfg_ff.viewport_y));
         REG_VP_W:       csr_prdata = CSR_DATA_W'(cfg_ff.viewport_width);
         REG_VP_H:       csr_prdata = CSR_DATA_W'(cfg_ff.viewport_height);
         REG_MARGIN:     csr_prdata = CSR_DATA_W'(cfg_ff.margin);
         REG_RECT_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.rect_limit);
         default:        csr_prdata = '0;
      endcase
   end

endmodule

// File: rtl/drc_ctrl.sv
// drc_ctrl: controller state machine sequencing adds and finish streaming
// depends on drc_pkg for state_type, cmd_type and sts_type
module drc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  drc_pkg::sts_type sts,
   output drc_pkg::cmd_type cmd
);
   import drc_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!sts.op_finish) begin
                  state_in = ST_ADD;
               end else if (sts.vp_empty || sts.tbl_empty) begin
                  state_in = ST_FIXED;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_ADD:   state_in = ST_IDLE;
         ST_EMIT: begin
            if (sts.out_free && sts.idx_last) state_in = ST_IDLE;
         end
         ST_FIXED: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:  cmd.edge_load  = accept && !sts.op_finish;
         ST_ADD:   cmd.add_commit = 1'b1;
         ST_EMIT: begin
            cmd.emit_entry  = sts.out_free;
            cmd.count_clear = sts.out_free && sts.idx_last;
         end
         ST_FIXED: begin
            cmd.emit_fixed  = sts.out_free;
            cmd.count_clear = sts.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/drc_dp.sv
// drc_dp: edge arithmetic, clipping, rectangle table, union and result register
// depends on drc_pkg for payload types, cmd/sts structs and edge helpers
module drc_dp (
   input  logic             clock,
   input  logic             reset,
   input  drc_pkg::req_type req_payload,
   input  drc_pkg::cfg_type cfg,
   input  drc_pkg::cmd_type cmd,
   output drc_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output drc_pkg::rsp_type rsp_payload
);
   import drc_pkg::*;

   // rectangle table, read data registered
   rect_type             mem [TABLE_DEPTH];
   rect_type             rd_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   rect_type             wr_data;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;

   // grown and saturated edges of the pending add
   coord_type            l_ff, t_ff, r_ff, b_ff;
   logic                 empty_ff;
   coord_type            vp_r_ff, vp_b_ff;

   edge_type             x_e, y_e, w_e, h_e, m_e;
   edge_type             l_sum, t_sum, r_sum, b_sum, vr_sum, vb_sum;

   coord_type            x1, y1, x2, y2;
   logic                 keep;
   logic [LIM_W-1:0]     mr, lim;
   logic                 merge;
   coord_type            f_r, f_b, ux1, uy1, ux2, uy2;

   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   logic                 out_free;

   assign x_e   = EDGE_W'(req_payload.rect_x);
   assign y_e   = EDGE_W'(req_payload.rect_y);
   assign w_e   = EDGE_W'(req_payload.rect_width);
   assign h_e   = EDGE_W'(req_payload.rect_height);
   assign m_e   = EDGE_W'(cfg.margin);
   assign l_sum = x_e - m_e;
   assign t_sum = y_e - m_e;
   assign r_sum = x_e + w_e + m_e;
   assign b_sum = y_e + h_e + m_e;

   assign vr_sum = EDGE_W'(cfg.viewport_x) + EDGE_W'(cfg.viewport_width);
   assign vb_sum = EDGE_W'(cfg.viewport_y) + EDGE_W'(cfg.viewport_height);

   always_ff @(posedge clock) begin
      vp_r_ff <= sat_edge(vr_sum);
      vp_b_ff <= sat_edge(vb_sum);
      if (cmd.edge_load) begin
         l_ff     <= sat_edge(l_sum);
         t_ff     <= sat_edge(t_sum);
         r_ff     <= sat_edge(r_sum);
         b_ff     <= sat_edge(b_sum);
         empty_ff <= (req_payload.rect_width == '0) || (req_payload.rect_height == '0);
      end
   end

   // clip against the viewport
   assign x1   = cmax(l_ff, cfg.viewport_x);
   assign y1   = cmax(t_ff, cfg.viewport_y);
   assign x2   = cmin(r_ff, vp_r_ff);
   assign y2   = cmin(b_ff, vp_b_ff);
   assign keep = !empty_ff && (x2 > x1) && (y2 > y1);

   // effective table limit, clamped to one..depth
   assign mr  = LIM_W'(cfg.rect_limit);
   always_comb begin
      if (mr == '0) begin
         lim = LIM_W'(1);
      end else if (mr > LIM_W'(TABLE_DEPTH)) begin
         lim = LIM_W'(TABLE_DEPTH);
      end else begin
         lim = mr;
      end
   end
   assign merge = (LIM_W'(count_ff) >= lim);

   // bounding box with entry zero, held in rd_ff during the add
   assign f_r = coord_type'(rd_ff.x + coord_type'(rd_ff.w));
   assign f_b = coord_type'(rd_ff.y + coord_type'(rd_ff.h));
   assign ux1 = cmin(rd_ff.x, x1);
   assign uy1 = cmin(rd_ff.y, y1);
   assign ux2 = cmax(f_r, x2);
   assign uy2 = cmax(f_b, y2);

   assign wr_en   = cmd.add_commit && keep;
   assign wr_addr = merge ? '0 : count_ff[IDX_W-1:0];
   always_comb begin
      if (merge) begin
         wr_data = '{x: ux1, y: uy1, w: span(ux1, ux2), h: span(uy1, uy2)};
      end else begin
         wr_data = '{x: x1, y: y1, w: span(x1, x2), h: span(y1, y2)};
      end
   end

   // read ahead one entry whenever the current one moves to the output
   assign rd_addr = cmd.emit_entry ? IDX_W'(idx_ff + 1'b1) : idx_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      if (wr_en && !merge) count_in = count_ff + CNT_W'(1);
      if (cmd.emit_entry)  idx_in   = IDX_W'(idx_ff + 1'b1);
      if (cmd.count_clear) begin
         count_in = '0;
         idx_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   // result register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_entry || cmd.emit_fixed) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_entry) begin
         rsp_ff <= '{mode: MODE_DIRTY, fallback: 1'b0, out_x: rd_ff.x, out_y: rd_ff.y,
                     out_width: rd_ff.w, out_height: rd_ff.h, last: sts.idx_last};
      end else if (cmd.emit_fixed) begin
         if (sts.vp_empty) begin
            rsp_ff <= '{mode: MODE_CLEAN, fallback: 1'b0, out_x: '0, out_y: '0,
                        out_width: '0, out_height: '0, last: 1'b1};
         end else begin
            rsp_ff <= '{mode: MODE_FULL, fallback: 1'b1, out_x: cfg.viewport_x,
                        out_y: cfg.viewport_y, out_width: cfg.viewport_width,
                        out_height: cfg.viewport_height, last: 1'b1};
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign sts.op_finish = (req_payload.opcode == OP_FINISH);
   assign sts.vp_empty  = (cfg.viewport_width == '0) || (cfg.viewport_height == '0);
   assign sts.tbl_empty = (count_ff == '0);
   assign sts.idx_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign sts.out_free  = out_free;

endmodule

// File: rtl/drc_checker.sv
// drc_checker: port-level assertions on the result channel, bound to the top level
// depends on drc_pkg for rsp_type and the mode codes
module drc_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input drc_pkg::rsp_type rsp_payload
);
   import drc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_nonlast_dirty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last |-> rsp_payload.mode == MODE_DIRTY)
      else $error("only dirty rectangles may precede the last result");

   a_clean_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.mode == MODE_CLEAN |->
         rsp_payload.last && !rsp_payload.fallback &&
         rsp_payload.out_width == '0 && rsp_payload.out_height == '0)
      else $error("malformed clean result");

   a_fallback_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.fallback || rsp_payload.mode == MODE_FULL) |->
         rsp_payload.fallback && rsp_payload.mode == MODE_FULL && rsp_payload.last)
      else $error("fallback and full-frame mode disagree");

endmodule

bind dirty_rect_coalescer drc_checker u_drc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
